// ----- rtl/huffman_bit_packer_assert.svh -----
// Assertion helpers used by the packer back end.
`ifndef HUFFMAN_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_BIT_PACKER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define HBP_ASSERT_IMP(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("hbp assertion failed");

// Next-cycle implication, disabled while in reset.
`define HBP_ASSERT_NEXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("hbp assertion failed");

`endif

// ----- rtl/hbp_pkg.sv -----
package hbp_pkg;

	// Input modes
	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_ENCODE = 2'd1;
	localparam logic [1:0] MODE_FLUSH  = 2'd2;

	// Fixed field widths
	localparam int CODE_W = 32;
	localparam int LEN_W  = 6;
	localparam int PEND_W = 7;
	localparam int BUF_W  = CODE_W + 8;

	// Default longest accepted code
	localparam int MAX_CODE_LEN_DEF = 32;

	// Most bytes one encode can produce (7 pending + 32 code bits)
	localparam int MAX_BYTES = (PEND_W + CODE_W) / 8;

	// Command queue between front and back
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	typedef struct packed {
		logic [1:0]        mode;
		logic [7:0]        symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	// Classified work for the back end: flush, or a code to append
	typedef struct packed {
		logic              flush;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} cmd_t;

endpackage

// ----- rtl/hbp_ram.sv -----
module hbp_ram import hbp_pkg::*; #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/hbp_front.sv -----
module hbp_front import hbp_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  in_item_t              item,
	input  logic [CMDQ_CNT_W-1:0] q_count,
	output logic                  q_push,
	output cmd_t                  q_cmd
);

	localparam int TLEN_W  = $clog2(MAX_CODE_LEN + 1);
	localparam int ENTRY_W = MAX_CODE_LEN + TLEN_W;

	logic               accept;
	logic               tbl_we;
	logic [CODE_W-1:0]  code_mask;
	logic [ENTRY_W-1:0] tbl_wdata;
	logic [ENTRY_W-1:0] tbl_rdata;
	logic [TLEN_W-1:0]  rd_len;
	logic [LEN_W-1:0]   clen;
	logic               valid_s1;
	logic               flush_s1;

	// Reserve a queue slot for every item still in flight
	assign full   = ((CMDQ_CNT_W + 1)'(q_count) + (CMDQ_CNT_W + 1)'(valid_s1))
			>= (CMDQ_CNT_W + 1)'(CMDQ_DEPTH);
	assign accept = push && !full;

	// Table write: overlong codes are dropped, stray high bits masked
	assign code_mask = ~({CODE_W{1'b1}} << item.code_length);
	assign tbl_we    = accept && (item.mode == MODE_LOAD)
			&& (item.code_length <= LEN_W'(MAX_CODE_LEN));
	assign tbl_wdata = {MAX_CODE_LEN'(item.code_bits & code_mask),
			TLEN_W'(item.code_length)};

	hbp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(256)
	) u_code_tbl (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(item.symbol),
		.wdata(tbl_wdata),
		.raddr(item.symbol),
		.rdata(tbl_rdata)
	);

	// Stage 1 tracks encode and flush transactions awaiting table data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && ((item.mode == MODE_ENCODE) || (item.mode == MODE_FLUSH));
		end
	end

	always_ff @(posedge clk) begin
		flush_s1 <= (item.mode == MODE_FLUSH);
	end

	// Classify: empty codes produce nothing and are dropped here
	assign rd_len = tbl_rdata[TLEN_W-1:0];
	assign clen   = (LEN_W'(rd_len) > LEN_W'(CODE_W)) ? LEN_W'(CODE_W) : LEN_W'(rd_len);

	assign q_cmd.flush = flush_s1;
	assign q_cmd.code  = CODE_W'(tbl_rdata[ENTRY_W-1:TLEN_W]);
	assign q_cmd.len   = clen;
	assign q_push      = valid_s1 && (flush_s1 || (clen != '0));

endmodule

// ----- rtl/hbp_cmd_fifo.sv -----
module hbp_cmd_fifo import hbp_pkg::*; #(
	parameter int DEPTH = CMDQ_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  cmd_t                           wr_data,
	input  logic                           rd_en,
	output cmd_t                           rd_data,
	output logic                           empty,
	output logic [$clog2(DEPTH + 1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= CNT_W'(count_q + 1'b1);
				2'b01:   count_q <= CNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_data = entry_q[rd_ptr_q];
	assign empty   = (count_q == '0);
	assign count   = count_q;

endmodule

// ----- rtl/hbp_back.sv -----
`include "huffman_bit_packer_assert.svh"

module hbp_back import hbp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  cmd_t      q_cmd,
	output logic      q_take,
	input  logic      pop,
	output logic      empty,
	output out_item_t result
);

	localparam int NB_W = $clog2(MAX_BYTES + 1);

	logic [PEND_W-1:0] pend_q;
	logic [2:0]        cnt_q;
	logic [BUF_W-1:0]  buf_q;
	logic [NB_W-1:0]   nleft_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [CODE_W-1:0] code_la;
	logic [BUF_W-1:0]  enc_buf;
	logic [BUF_W-1:0]  enc_rest;
	logic [LEN_W-1:0]  tot;
	logic [BUF_W-1:0]  new_buf;
	logic [NB_W-1:0]   new_nb;
	logic [PEND_W-1:0] new_pend;
	logic [2:0]        new_cnt;
	logic              emit;

	// Merge pending bits and the left-aligned code into one window
	assign code_la  = CODE_W'(q_cmd.code << (LEN_W'(CODE_W) - q_cmd.len));
	assign enc_buf  = {pend_q, (BUF_W - PEND_W)'(0)} | ({code_la, 8'h00} >> cnt_q);
	assign tot      = LEN_W'(cnt_q) + q_cmd.len;
	assign enc_rest = BUF_W'(enc_buf << {tot[LEN_W-1:3], 3'b000});

	always_comb begin
		if (q_cmd.flush) begin
			new_buf  = {pend_q, (BUF_W - PEND_W)'(0)};
			new_nb   = NB_W'(1);
			new_pend = '0;
			new_cnt  = '0;
		end else begin
			new_buf  = enc_buf;
			new_nb   = NB_W'(tot[LEN_W-1:3]);
			new_pend = enc_rest[BUF_W-1 -: PEND_W];
			new_cnt  = tot[2:0];
		end
	end

	// Byte issue into the output register; next command on the last byte
	assign emit   = (nleft_q != '0) && (!out_valid_q || pop);
	assign q_take = !q_empty && ((nleft_q == '0) || ((nleft_q == NB_W'(1)) && emit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			cnt_q       <= '0;
			nleft_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_take) begin
				pend_q  <= new_pend;
				cnt_q   <= new_cnt;
				nleft_q <= new_nb;
			end else if (emit) begin
				nleft_q <= NB_W'(nleft_q - 1'b1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Byte window and output payload
	always_ff @(posedge clk) begin
		if (q_take) begin
			buf_q <= new_buf;
		end else if (emit) begin
			buf_q <= BUF_W'(buf_q << 8);
		end
		if (emit) begin
			out_q.out_byte <= buf_q[BUF_W-1 -: 8];
			out_q.last     <= (nleft_q == NB_W'(1));
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	`HBP_ASSERT_IMP(a_take_nonempty, clk, arst_n, q_take, !q_empty)
	`HBP_ASSERT_IMP(a_nleft_range, clk, arst_n, 1'b1, nleft_q <= NB_W'(MAX_BYTES))
	`HBP_ASSERT_IMP(a_pend_clean, clk, arst_n, 1'b1, PEND_W'(pend_q << cnt_q) == '0)
	`HBP_ASSERT_NEXT(a_out_held, clk, arst_n, out_valid_q && !pop, out_valid_q)

endmodule

// ----- rtl/huffman_bit_packer.sv -----
// Huffman bit packer: load transactions write one code-table entry per cycle while
// not full; encode transactions append the symbol's code MSB first and emit each
// completed byte, and flush transactions emit one zero-padded byte with the pending
// bits. A new transaction is taken every cycle while the four-entry command queue has
// room; the back end drains it at one output byte per cycle while results are popped,
// so an encode that completes n bytes (up to 4) takes n output slots, and that
// one-byte-per-cycle output register sets the sustained rate. A result passes the
// table read, the command queue, the byte window and the output register in order.
// Encoding a symbol that was never loaded gives undefined bytes.
module huffman_bit_packer import hbp_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic                  q_push;
	cmd_t                  q_wr_cmd;
	cmd_t                  q_rd_cmd;
	logic                  q_take;
	logic                  q_empty;
	logic [CMDQ_CNT_W-1:0] q_count;

	hbp_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_count(q_count),
		.q_push (q_push),
		.q_cmd  (q_wr_cmd)
	);

	hbp_cmd_fifo #(
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(q_wr_cmd),
		.rd_en  (q_take),
		.rd_data(q_rd_cmd),
		.empty  (q_empty),
		.count  (q_count)
	);

	hbp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_cmd  (q_rd_cmd),
		.q_take (q_take),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule
